/* hw/rtl/md5rk_pkg.sv */
// ----------------------------------------------------------------------------
// md5rk_pkg
// Types and constants shared by the rolling-key MD5 decrypt unit.
// ----------------------------------------------------------------------------
package md5rk_pkg;

    typedef struct packed {
        logic [31:0] cipher_word;
        logic        is_header;
    } t_in_item;

    typedef struct packed {
        logic [31:0] plain_word;
        logic [2:0]  valid_bytes;
    } t_out_item;

    localparam logic [31:0] IV_A = 32'h67452301;
    localparam logic [31:0] IV_B = 32'hefcdab89;
    localparam logic [31:0] IV_C = 32'h98badcfe;
    localparam logic [31:0] IV_D = 32'h10325476;

    localparam logic [7:0] REG_INITIAL_KEY = 8'd0;

    function automatic logic [31:0] md5_k(input logic [5:0] i);
        logic [31:0] r;
        case (i)
            6'd0: r = 32'hd76aa478;  6'd1: r = 32'he8c7b756;
            6'd2: r = 32'h242070db;  6'd3: r = 32'hc1bdceee;
            6'd4: r = 32'hf57c0faf;  6'd5: r = 32'h4787c62a;
            6'd6: r = 32'ha8304613;  6'd7: r = 32'hfd469501;
            6'd8: r = 32'h698098d8;  6'd9: r = 32'h8b44f7af;
            6'd10: r = 32'hffff5bb1; 6'd11: r = 32'h895cd7be;
            6'd12: r = 32'h6b901122; 6'd13: r = 32'hfd987193;
            6'd14: r = 32'ha679438e; 6'd15: r = 32'h49b40821;
            6'd16: r = 32'hf61e2562; 6'd17: r = 32'hc040b340;
            6'd18: r = 32'h265e5a51; 6'd19: r = 32'he9b6c7aa;
            6'd20: r = 32'hd62f105d; 6'd21: r = 32'h02441453;
            6'd22: r = 32'hd8a1e681; 6'd23: r = 32'he7d3fbc8;
            6'd24: r = 32'h21e1cde6; 6'd25: r = 32'hc33707d6;
            6'd26: r = 32'hf4d50d87; 6'd27: r = 32'h455a14ed;
            6'd28: r = 32'ha9e3e905; 6'd29: r = 32'hfcefa3f8;
            6'd30: r = 32'h676f02d9; 6'd31: r = 32'h8d2a4c8a;
            6'd32: r = 32'hfffa3942; 6'd33: r = 32'h8771f681;
            6'd34: r = 32'h6d9d6122; 6'd35: r = 32'hfde5380c;
            6'd36: r = 32'ha4beea44; 6'd37: r = 32'h4bdecfa9;
            6'd38: r = 32'hf6bb4b60; 6'd39: r = 32'hbebfbc70;
            6'd40: r = 32'h289b7ec6; 6'd41: r = 32'heaa127fa;
            6'd42: r = 32'hd4ef3085; 6'd43: r = 32'h04881d05;
            6'd44: r = 32'hd9d4d039; 6'd45: r = 32'he6db99e5;
            6'd46: r = 32'h1fa27cf8; 6'd47: r = 32'hc4ac5665;
            6'd48: r = 32'hf4292244; 6'd49: r = 32'h432aff97;
            6'd50: r = 32'hab9423a7; 6'd51: r = 32'hfc93a039;
            6'd52: r = 32'h655b59c3; 6'd53: r = 32'h8f0ccc92;
            6'd54: r = 32'hffeff47d; 6'd55: r = 32'h85845dd1;
            6'd56: r = 32'h6fa87e4f; 6'd57: r = 32'hfe2ce6e0;
            6'd58: r = 32'ha3014314; 6'd59: r = 32'h4e0811a1;
            6'd60: r = 32'hf7537e82; 6'd61: r = 32'hbd3af235;
            6'd62: r = 32'h2ad7d2bb; 6'd63: r = 32'heb86d391;
            default: r = 32'h0;
        endcase
        return r;
    endfunction

    function automatic logic [4:0] md5_s(input logic [5:0] i);
        logic [4:0] r;
        case ({i[5:4], i[1:0]})
            4'd0: r = 5'd7;   4'd1: r = 5'd12;  4'd2: r = 5'd17;  4'd3: r = 5'd22;
            4'd4: r = 5'd5;   4'd5: r = 5'd9;   4'd6: r = 5'd14;  4'd7: r = 5'd20;
            4'd8: r = 5'd4;   4'd9: r = 5'd11;  4'd10: r = 5'd16; 4'd11: r = 5'd23;
            4'd12: r = 5'd6;  4'd13: r = 5'd10; 4'd14: r = 5'd15; 4'd15: r = 5'd21;
            default: r = 5'd7;
        endcase
        return r;
    endfunction

endpackage

/* hw/rtl/md5_rolling_key_xor_decrypt_unit.sv */
// ----------------------------------------------------------------------------
// md5_rolling_key_xor_decrypt_unit
// MD5 output-feedback stream decryptor with an APB register port.
// ----------------------------------------------------------------------------
// A header word does not start the round unit in the back end; a data word keeps
// it busy while the single MD5 round unit runs 64 rounds to advance the key.
// A two-entry queue in front and the output register let input and output
// stall independently. initial_key lives at address 0.
module md5_rolling_key_xor_decrypt_unit (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  md5rk_pkg::t_in_item  i_item,
    output logic                 o_valid,
    input  logic                 i_ready,
    output md5rk_pkg::t_out_item o_item,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [1:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);

    logic [31:0]         r_initial_key;
    logic                q_valid;
    logic                q_ready;
    md5rk_pkg::t_in_item q_item;

    assign pready = 1'b1;
    assign prdata = (paddr == 2'd0) ? r_initial_key : 32'h0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_initial_key <= 32'h0;
        end else if (psel && penable && pwrite && paddr == 2'd0) begin
            r_initial_key <= pwdata;
        end
    end

    md5rk_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_item  (i_item),
        .o_valid (q_valid),
        .i_ready (q_ready),
        .o_item  (q_item)
    );

    md5rk_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_initial_key (r_initial_key),
        .i_valid       (q_valid),
        .o_ready       (q_ready),
        .i_item        (q_item),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_item        (o_item)
    );

    a_vb_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_item.valid_bytes != 3'd0 && o_item.valid_bytes <= 3'd4))
        else $error("valid_bytes out of range");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_item)))
        else $error("output changed while stalled");

endmodule

/* hw/rtl/md5rk_front.sv */
// ----------------------------------------------------------------------------
// md5rk_front
// Accepts input items and queues them for the key engine.
// ----------------------------------------------------------------------------
module md5rk_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  md5rk_pkg::t_in_item i_item,
    output logic                o_valid,
    input  logic                i_ready,
    output md5rk_pkg::t_in_item o_item
);

    md5rk_pkg::t_in_item r_q [2];
    logic                r_wp;
    logic                r_rp;
    logic [1:0]          r_cnt;

    logic push;
    logic pop;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_item  = r_q[r_rp];
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
    end

endmodule

/* hw/rtl/md5rk_back.sv */
// ----------------------------------------------------------------------------
// md5rk_back
// Decrypts data words and advances the rolling key, one MD5 round a cycle.
// ----------------------------------------------------------------------------
module md5rk_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic [31:0]          i_initial_key,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  md5rk_pkg::t_in_item  i_item,
    output logic                 o_valid,
    input  logic                 i_ready,
    output md5rk_pkg::t_out_item o_item
);

    logic [31:0] r_key;
    logic [30:0] r_left;
    logic        r_busy;
    logic [5:0]  r_rnd;
    logic [31:0] r_a, r_b, r_c, r_d;
    logic        r_ov;
    md5rk_pkg::t_out_item r_out;

    logic [31:0] f, m, sum, rot;
    logic [3:0]  g;
    logic [4:0]  s;
    logic        take;

    assign o_ready = !r_busy && (!r_ov || i_ready);
    assign take    = i_valid && o_ready;
    assign o_valid = r_ov;
    assign o_item  = r_out;

    always_comb begin
        case (r_rnd[5:4])
            2'd0: begin
                f = (r_b & r_c) | (~r_b & r_d);
                g = r_rnd[3:0];
            end
            2'd1: begin
                f = (r_d & r_b) | (~r_d & r_c);
                g = 4'(5 * r_rnd[3:0] + 1);
            end
            2'd2: begin
                f = r_b ^ r_c ^ r_d;
                g = 4'(3 * r_rnd[3:0] + 5);
            end
            default: begin
                f = r_c ^ (r_b | ~r_d);
                g = 4'(7 * r_rnd[3:0]);
            end
        endcase
        case (g)
            4'd0:    m = r_key;
            4'd1:    m = 32'h80;
            4'd14:   m = 32'd32;
            default: m = 32'h0;
        endcase
        s   = md5rk_pkg::md5_s(r_rnd);
        sum = r_a + f + md5rk_pkg::md5_k(r_rnd) + m;
        rot = (sum << s) | (sum >> (6'd32 - {1'b0, s}));
    end

    always_ff @(posedge i_clk) begin
        if (take && !i_item.is_header && r_left != 31'd0) begin
            r_out.plain_word  <= i_item.cipher_word ^ r_key;
            r_out.valid_bytes <= (r_left >= 31'd4) ? 3'd4 : r_left[2:0];
        end
        if (take) begin
            r_a <= md5rk_pkg::IV_A;
            r_b <= md5rk_pkg::IV_B;
            r_c <= md5rk_pkg::IV_C;
            r_d <= md5rk_pkg::IV_D;
        end else if (r_busy) begin
            r_a <= r_d;
            r_d <= r_c;
            r_c <= r_b;
            r_b <= r_b + rot;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key  <= 32'h0;
            r_left <= 31'd0;
            r_busy <= 1'b0;
            r_rnd  <= 6'd0;
            r_ov   <= 1'b0;
        end else begin
            if (take && !i_item.is_header && r_left != 31'd0) begin
                r_ov <= 1'b1;
            end else if (r_ov && i_ready) begin
                r_ov <= 1'b0;
            end
            if (take) begin
                if (i_item.is_header) begin
                    r_key  <= i_initial_key;
                    r_left <= i_item.cipher_word[31] ? 31'd0 : i_item.cipher_word[30:0];
                end else begin
                    r_busy <= 1'b1;
                    r_rnd  <= 6'd0;
                    r_left <= (r_left >= 31'd4) ? r_left - 31'd4 : 31'd0;
                end
            end else if (r_busy) begin
                r_rnd <= r_rnd + 6'd1;
                if (r_rnd == 6'd63) begin
                    r_busy <= 1'b0;
                    r_key  <= r_key ^ (r_c + md5rk_pkg::IV_D);
                end
            end
        end
    end

endmodule

/* bench/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for md5_rolling_key_xor_decrypt_unit: directed table of
// headers and data words, then random framed streams, checked against an
// in-bench rolling-key predictor under three sender/receiver idling mixes.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SETTLE_CYCLES = 256;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam logic [1:0] ADDR_INITIAL_KEY = 2'(4 * md5rk_pkg::REG_INITIAL_KEY);

    localparam logic [31:0] RND_ADD [64] = '{
        32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
        32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
        32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
        32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
        32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
        32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
        32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
        32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
        32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
        32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
        32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
        32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
        32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
        32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
        32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
        32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
    };
    localparam int RND_SHIFT [16] = '{7, 12, 17, 22, 5, 9, 14, 20,
                                      4, 11, 16, 23, 6, 10, 15, 21};

    typedef enum logic [1:0] {CHK_PREDICT, CHK_NONE, CHK_TYPED} t_chk;

    typedef struct {
        logic [31:0] word;
        logic        hdr;
        t_chk        chk;
        logic [31:0] plain;
        logic [2:0]  nbytes;
    } t_row;

    logic i_clk, i_rst_n;
    logic i_valid, o_ready, o_valid, i_ready;
    md5rk_pkg::t_in_item i_item;
    md5rk_pkg::t_out_item o_item;
    logic psel, penable, pwrite, pready;
    logic [1:0] paddr;
    logic [31:0] pwdata, prdata;

    // predictor state
    logic [31:0] key_init, key_roll;
    logic [30:0] bytes_left;

    md5rk_pkg::t_out_item plain_q[$];
    md5rk_pkg::t_out_item exp_item;
    int mismatches = 0;
    int cycles = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;

    md5_rolling_key_xor_decrypt_unit i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_ready(o_ready), .i_item(i_item),
        .o_valid(o_valid), .i_ready(i_ready), .o_item(o_item),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic logic [31:0] digest_word3(logic [31:0] k);
        logic [31:0] blk [16];
        logic [31:0] a, b, c, d, f, t, s;
        int g;
        for (int j = 0; j < 16; j++) blk[j] = 32'h0;
        blk[0] = k;
        blk[1] = 32'h80;
        blk[14] = 32'd32;
        a = 32'h67452301; b = 32'hefcdab89; c = 32'h98badcfe; d = 32'h10325476;
        for (int i = 0; i < 64; i++) begin
            case (i / 16)
                0: begin f = (b & c) | (~b & d); g = i; end
                1: begin f = (d & b) | (~d & c); g = (5 * i + 1) % 16; end
                2: begin f = b ^ c ^ d; g = (3 * i + 5) % 16; end
                default: begin f = c ^ (b | ~d); g = (7 * i) % 16; end
            endcase
            s = a + f + RND_ADD[i] + blk[g];
            t = d;
            d = c;
            c = b;
            b = b + ((s << RND_SHIFT[(i / 16) * 4 + i % 4])
                     | (s >> (32 - RND_SHIFT[(i / 16) * 4 + i % 4])));
            a = t;
        end
        return d + 32'h10325476;
    endfunction

    // advance predictor by one accepted word; returns 1 when a result is due
    function automatic bit decrypt_step(md5rk_pkg::t_in_item it,
                                        output md5rk_pkg::t_out_item res);
        res = '0;
        if (it.is_header) begin
            key_roll = key_init;
            bytes_left = it.cipher_word[31] ? 31'd0 : it.cipher_word[30:0];
            return 1'b0;
        end
        decrypt_step = (bytes_left != 0);
        res.plain_word = it.cipher_word ^ key_roll;
        res.valid_bytes = (bytes_left >= 4) ? 3'd4 : 3'(bytes_left);
        key_roll = key_roll ^ digest_word3(key_roll);
        bytes_left = (bytes_left >= 4) ? bytes_left - 31'd4 : 31'd0;
    endfunction

    always @(negedge i_clk) begin
        i_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("** md5_rolling_key_xor_decrypt_unit: FAILED **");
            $finish;
        end
        if (i_rst_n && o_valid && i_ready) begin
            if (plain_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected transfer: word %h bytes %0d",
                             o_item.plain_word, o_item.valid_bytes);
            end else begin
                exp_item = plain_q.pop_front();
                if (o_item.plain_word !== exp_item.plain_word
                    || o_item.valid_bytes !== exp_item.valid_bytes) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp word %h bytes %0d, got word %h bytes %0d",
                                 exp_item.plain_word, exp_item.valid_bytes,
                                 o_item.plain_word, o_item.valid_bytes);
                end
            end
        end
    end

    task automatic send_word(md5rk_pkg::t_in_item it, t_chk chk,
                             md5rk_pkg::t_out_item typed);
        md5rk_pkg::t_out_item res;
        bit has;
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_item <= it;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        has = decrypt_step(it, res);
        if (chk == CHK_TYPED) plain_q.push_back(typed);
        else if (chk == CHK_PREDICT && has) plain_q.push_back(res);
        @(negedge i_clk);
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (plain_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_initial_key(logic [31:0] value);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= ADDR_INITIAL_KEY; pwdata <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        key_init = value;
        @(negedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic random_phase(int n_items, int s_idle, int r_stall);
        md5rk_pkg::t_in_item it;
        logic [31:0] size;
        int nwords, pick, sent;
        send_idle_pct = s_idle;
        recv_stall_pct = r_stall;
        sent = 0;
        while (sent < n_items) begin
            pick = $urandom_range(99);
            if (pick < 85) begin
                pick = $urandom_range(99);
                if (pick < 70) size = $urandom_range(48, 1);
                else if (pick < 80) size = 32'd0;
                else if (pick < 90) size = {1'b1, 31'($urandom)};
                else size = {1'b0, 31'($urandom)};
                if (size[31] || size > 32'd80) nwords = $urandom_range(12, 1);
                else nwords = (size + 3) / 4 + $urandom_range(2);
                it.cipher_word = size;
                it.is_header = 1'b1;
                send_word(it, CHK_PREDICT, '0);
                sent++;
                for (int w = 0; w < nwords; w++) begin
                    it.cipher_word = $urandom;
                    it.is_header = 1'b0;
                    send_word(it, CHK_PREDICT, '0);
                    sent++;
                end
            end else begin
                it.cipher_word = $urandom;
                it.is_header = ($urandom_range(99) < 5);
                send_word(it, CHK_PREDICT, '0);
                sent++;
            end
        end
        drain();
    endtask

    t_row rows [] = '{
        '{32'hdeadbeef, 1'b0, CHK_NONE,    32'h0,        3'd0},
        '{32'h80000000, 1'b1, CHK_NONE,    32'h0,        3'd0},
        '{32'hffffffff, 1'b0, CHK_NONE,    32'h0,        3'd0},
        '{32'h00000005, 1'b1, CHK_NONE,    32'h0,        3'd0},
        '{32'h12345678, 1'b0, CHK_TYPED,   32'h12345678, 3'd4},
        '{32'hffffffff, 1'b0, CHK_PREDICT, 32'h0,        3'd0},
        '{32'h00000000, 1'b0, CHK_NONE,    32'h0,        3'd0},
        '{32'h7fffffff, 1'b1, CHK_NONE,    32'h0,        3'd0},
        '{32'h00000000, 1'b0, CHK_TYPED,   32'h00000000, 3'd4},
        '{32'ha5a5a5a5, 1'b0, CHK_PREDICT, 32'h0,        3'd0},
        '{32'h00000002, 1'b1, CHK_NONE,    32'h0,        3'd0},
        '{32'hffffffff, 1'b0, CHK_TYPED,   32'hffffffff, 3'd2},
        '{32'h00000003, 1'b1, CHK_NONE,    32'h0,        3'd0},
        '{32'h00000000, 1'b0, CHK_TYPED,   32'h00000000, 3'd3},
        '{32'h00000004, 1'b1, CHK_NONE,    32'h0,        3'd0},
        '{32'h80000001, 1'b0, CHK_TYPED,   32'h80000001, 3'd4},
        '{32'h5a5a5a5a, 1'b0, CHK_NONE,    32'h0,        3'd0},
        '{32'h00000000, 1'b1, CHK_NONE,    32'h0,        3'd0},
        '{32'h0000ffff, 1'b0, CHK_NONE,    32'h0,        3'd0}
    };

    initial begin
        md5rk_pkg::t_in_item it;
        md5rk_pkg::t_out_item typed;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_item = '0;
        i_ready = 1'b0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        key_init = '0; key_roll = '0; bytes_left = '0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed table, key still at its reset value of zero
        send_idle_pct = 31;
        recv_stall_pct = 64;
        foreach (rows[r]) begin
            it.cipher_word = rows[r].word;
            it.is_header = rows[r].hdr;
            typed.plain_word = rows[r].plain;
            typed.valid_bytes = rows[r].nbytes;
            send_word(it, rows[r].chk, typed);
        end
        drain();

        write_initial_key(32'hffffffff);
        random_phase(480, 31, 64);
        write_initial_key($urandom);
        random_phase(480, 64, 31);
        write_initial_key(32'h0);
        random_phase(470, 0, 0);

        if (mismatches == 0 && plain_q.size() == 0) begin
            $display("** md5_rolling_key_xor_decrypt_unit: PASSED **");
        end else begin
            $display("** md5_rolling_key_xor_decrypt_unit: FAILED **");
        end
        $finish;
    end
endmodule
